// File: rtl/dsp_general_instruction_execute_macros.svh
// Assertion macros for the DSP general instruction execute block.
// Included by the top level; no other dependencies.
`ifndef DSP_GENERAL_INSTRUCTION_EXECUTE_MACROS_SVH
`define DSP_GENERAL_INSTRUCTION_EXECUTE_MACROS_SVH

`define DGIE_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

`define DGIE_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

// File: rtl/dgie_pkg.sv
// Package for the DSP general instruction execute block.
// Holds the decoded instruction type, operation codes and widths; no dependencies.
package dgie_pkg;

    localparam int BANK_DEPTH_DEF = 64;
    localparam int NUM_BANKS      = 4;
    localparam int CNT_W          = 6;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [3:0] {
        ALU_NOP = 4'd0,
        ALU_AND = 4'd1,
        ALU_OR  = 4'd2,
        ALU_XOR = 4'd3,
        ALU_ADD = 4'd4,
        ALU_SUB = 4'd5,
        ALU_AD2 = 4'd6,
        ALU_SR  = 4'd8,
        ALU_RR  = 4'd9,
        ALU_SL  = 4'd10,
        ALU_RL  = 4'd11,
        ALU_RL8 = 4'd15
    } alu_op_t;

    localparam logic [3:0] DST_RX  = 4'd4;
    localparam logic [3:0] DST_P   = 4'd5;
    localparam logic [3:0] DST_RAO = 4'd6;
    localparam logic [3:0] DST_WAO = 4'd7;
    localparam logic [3:0] DST_LOP = 4'd10;
    localparam logic [3:0] DST_TOP = 4'd11;

    localparam logic [3:0] SRC_ALU_LO = 4'd9;
    localparam logic [3:0] SRC_ALU_HI = 4'd10;

    localparam logic [11:0] LOP_FULL = 12'hFFF;

    typedef struct packed {
        alu_op_t    alu_op;
        logic       x_mul;
        logic       x_rd;
        logic       x_ldp;
        logic       x_ldrx;
        logic [1:0] x_bank;
        logic       x_inc;
        logic       y_clr;
        logic       y_alu;
        logic       y_rd;
        logic       y_ldac;
        logic       y_ldry;
        logic [1:0] y_bank;
        logic       y_inc;
        logic       d1_en;
        logic       d1_reg;
        logic [3:0] d1_dest;
        logic [7:0] d1_field;
        logic       looped;
    } dec_inst_t;

endpackage

// File: rtl/dsp_general_instruction_execute.sv
// Top level of the DSP general instruction execute block.
// Depends on dgie_pkg, dgie_front, dgie_back and the assertion macro header.
//
// Usage:
// The input channel (in_valid, in_ready) takes one decoded general instruction
// per transfer. The output channel (out_valid, out_ready) gives one transfer per
// instruction with the accumulator, product, RX, RY, flags, LOP, TOP and the
// four bank counters as they stand after that instruction.
// An input transfer is written into the decode queue, and the result is offered
// from the execute stage, whose state
// registers drive the outputs directly.
// Throughput is one instruction per cycle while the receiver takes results, set by
// the single execute stage, whose register update the next instruction reads back.
// The two-entry queue keeps accepting while a result waits; when the receiver
// stalls, execution holds and the queue fills, and in_ready then falls.
// Reset clears the state registers, the queue pointers and count and the bank
// valid bits at once, so all bank words read as zero; no clearing pass follows.
`include "dsp_general_instruction_execute_macros.svh"

module dsp_general_instruction_execute #(
    parameter int BANK_DEPTH = dgie_pkg::BANK_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  operation,
    input  logic [2:0]  x_op,
    input  logic [2:0]  x_source,
    input  logic [2:0]  y_op,
    input  logic [2:0]  y_source,
    input  logic [1:0]  d1_op,
    input  logic [3:0]  d1_dest,
    input  logic [7:0]  d1_field,
    input  logic        looped,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [47:0] accumulator,
    output logic [47:0] product,
    output logic [31:0] x_register,
    output logic [31:0] y_register,
    output logic        flag_sign,
    output logic        flag_zero,
    output logic        flag_carry,
    output logic        flag_overflow,
    output logic [11:0] loop_count,
    output logic [7:0]  top_register,
    output logic [23:0] bank_counters
);
    import dgie_pkg::*;

    logic      q_valid;
    logic      q_ready;
    dec_inst_t q_data;

    dgie_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .operation(operation),
        .x_op     (x_op),
        .x_source (x_source),
        .y_op     (y_op),
        .y_source (y_source),
        .d1_op    (d1_op),
        .d1_dest  (d1_dest),
        .d1_field (d1_field),
        .looped   (looped),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    dgie_back #(.BANK_DEPTH(BANK_DEPTH)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_data       (q_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .accumulator  (accumulator),
        .product      (product),
        .x_register   (x_register),
        .y_register   (y_register),
        .flag_sign    (flag_sign),
        .flag_zero    (flag_zero),
        .flag_carry   (flag_carry),
        .flag_overflow(flag_overflow),
        .loop_count   (loop_count),
        .top_register (top_register),
        .bank_counters(bank_counters)
    );

    `DGIE_ASSERT_NEXT(a_exec_gives_result, clk, rst_n, q_valid && q_ready, out_valid)
    `DGIE_ASSERT_IMPL(a_full_not_empty, clk, rst_n, !in_ready, q_valid)
    `DGIE_ASSERT_NEXT(a_full_holds, clk, rst_n, !in_ready && !q_ready, !in_ready)

endmodule

// File: rtl/dgie_front.sv
// Front end: decodes incoming instructions and queues them for execution.
// Depends on dgie_pkg.
module dgie_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [3:0]        operation,
    input  logic [2:0]        x_op,
    input  logic [2:0]        x_source,
    input  logic [2:0]        y_op,
    input  logic [2:0]        y_source,
    input  logic [1:0]        d1_op,
    input  logic [3:0]        d1_dest,
    input  logic [7:0]        d1_field,
    input  logic              looped,
    output logic              q_valid,
    input  logic              q_ready,
    output dgie_pkg::dec_inst_t q_data
);
    import dgie_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    dec_inst_t          dec;
    dec_inst_t          ent_reg [QUEUE_DEPTH];
    logic [PW-1:0]      wptr_reg;
    logic [PW-1:0]      rptr_reg;
    logic [CW-1:0]      cnt_reg;
    logic               push;
    logic               pop;

    always_comb
    begin
        unique case (operation)
            ALU_AND, ALU_OR, ALU_XOR, ALU_ADD, ALU_SUB, ALU_AD2,
            ALU_SR, ALU_RR, ALU_SL, ALU_RL, ALU_RL8: dec.alu_op = alu_op_t'(operation);
            default: dec.alu_op = ALU_NOP;
        endcase
        dec.x_mul    = (x_op[1:0] == 2'd2);
        dec.x_rd     = (x_op >= 3'd3);
        dec.x_ldp    = (x_op[1:0] == 2'd3);
        dec.x_ldrx   = x_op[2];
        dec.x_bank   = x_source[1:0];
        dec.x_inc    = x_source[2];
        dec.y_clr    = (y_op[1:0] == 2'd1);
        dec.y_alu    = (y_op[1:0] == 2'd2);
        dec.y_rd     = (y_op >= 3'd3);
        dec.y_ldac   = (y_op[1:0] == 2'd3);
        dec.y_ldry   = y_op[2];
        dec.y_bank   = y_source[1:0];
        dec.y_inc    = y_source[2];
        dec.d1_en    = d1_op[0];
        dec.d1_reg   = d1_op[1];
        dec.d1_dest  = d1_dest;
        dec.d1_field = d1_field;
        dec.looped   = looped;
    end

    assign in_ready = (cnt_reg != CW'(QUEUE_DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_data   = ent_reg[rptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= PW'((32'(wptr_reg) + 1) % QUEUE_DEPTH);
            end
            if (pop)
            begin
                rptr_reg <= PW'((32'(rptr_reg) + 1) % QUEUE_DEPTH);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

endmodule

// File: rtl/dgie_bank.sv
// One data bank: a word memory that keeps the word at its counter ready to read.
// Entries read as zero until written. No package dependencies.
module dgie_bank #(
    parameter int BANK_DEPTH = 64,
    parameter int AW         = $clog2(BANK_DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);
    logic [31:0]         mem [BANK_DEPTH];
    logic [BANK_DEPTH-1:0] vld_reg;
    logic [31:0]         mem_q_reg;
    logic                vld_q_reg;
    logic                byp_reg;
    logic [31:0]         byp_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        mem_q_reg    <= mem[raddr];
        byp_data_reg <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
            byp_reg   <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            vld_q_reg <= vld_reg[raddr];
            byp_reg   <= we && (waddr == raddr);
        end
    end

    assign rdata = byp_reg ? byp_data_reg : (vld_q_reg ? mem_q_reg : 32'd0);

endmodule

// File: rtl/dgie_back.sv
// Back end: executes one decoded instruction per cycle while the output is taken, and holds the registers.
// Depends on dgie_pkg and dgie_bank.
module dgie_back #(
    parameter int BANK_DEPTH = dgie_pkg::BANK_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  dgie_pkg::dec_inst_t q_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [47:0]         accumulator,
    output logic [47:0]         product,
    output logic [31:0]         x_register,
    output logic [31:0]         y_register,
    output logic                flag_sign,
    output logic                flag_zero,
    output logic                flag_carry,
    output logic                flag_overflow,
    output logic [11:0]         loop_count,
    output logic [7:0]          top_register,
    output logic [23:0]         bank_counters
);
    import dgie_pkg::*;

    localparam int AW = $clog2(BANK_DEPTH);

    logic [47:0]      acc_reg, acc_next;
    logic [47:0]      prod_reg, prod_next;
    logic [31:0]      rx_reg, rx_next;
    logic [31:0]      ry_reg, ry_next;
    logic [3:0]       flags_reg, flags_next;
    logic [31:0]      rao_reg, rao_next;
    logic [31:0]      wao_reg, wao_next;
    logic [11:0]      loop_reg, loop_next;
    logic [7:0]       top_reg, top_next;
    logic [CNT_W-1:0] addr_reg [NUM_BANKS];
    logic [CNT_W-1:0] addr_next [NUM_BANKS];
    logic             out_valid_reg;
    logic             fire;
    logic [31:0]      head [NUM_BANKS];
    logic [NUM_BANKS-1:0] bank_we;
    logic [31:0]      d1_val;
    logic [47:0]      alu;
    logic signed [63:0] mul;

    assign fire    = q_valid && (!out_valid_reg || out_ready);
    assign q_ready = !out_valid_reg || out_ready;
    assign mul     = $signed(rx_reg) * $signed(ry_reg);

    for (genvar g = 0; g < NUM_BANKS; g++)
    begin : g_bank
        dgie_bank #(.BANK_DEPTH(BANK_DEPTH), .AW(AW)) u_bank (
            .clk   (clk),
            .rst_n (rst_n),
            .we    (fire && bank_we[g]),
            .waddr (addr_reg[g][AW-1:0]),
            .wdata (d1_val),
            .raddr (fire ? addr_next[g][AW-1:0] : addr_reg[g][AW-1:0]),
            .rdata (head[g])
        );
    end

    always_comb
    begin
        logic [31:0]          a;
        logic [31:0]          p;
        logic [32:0]          t33;
        logic [48:0]          t49;
        logic [31:0]          r;
        logic                 c;
        logic                 upd32;
        logic [NUM_BANKS-1:0] rd;
        logic [NUM_BANKS-1:0] inc;
        logic [31:0]          v;
        logic [1:0]           sb;
        a          = acc_reg[31:0];
        p          = prod_reg[31:0];
        t33        = '0;
        t49        = '0;
        r          = a;
        c          = 1'b0;
        upd32      = 1'b1;
        alu        = acc_reg;
        flags_next = flags_reg;
        case (q_data.alu_op)
            ALU_AND: r = a & p;
            ALU_OR:  r = a | p;
            ALU_XOR: r = a ^ p;
            ALU_ADD:
            begin
                t33 = {1'b0, a} + {1'b0, p};
                r   = t33[31:0];
                c   = t33[32];
                flags_next[3] = flags_reg[3] | (~(a[31] ^ p[31]) & (a[31] ^ r[31]));
            end
            ALU_SUB:
            begin
                t33 = {1'b0, a} - {1'b0, p};
                r   = t33[31:0];
                c   = t33[32];
                flags_next[3] = flags_reg[3] | ((a[31] ^ p[31]) & (a[31] ^ r[31]));
            end
            ALU_SR:  begin r = {a[31], a[31:1]}; c = a[0]; end
            ALU_RR:  begin r = {a[0], a[31:1]}; c = a[0]; end
            ALU_SL:  begin r = {a[30:0], 1'b0}; c = a[31]; end
            ALU_RL:  begin r = {a[30:0], a[31]}; c = a[31]; end
            ALU_RL8: begin r = {a[23:0], a[31:24]}; c = a[24]; end
            ALU_AD2:
            begin
                upd32 = 1'b0;
                t49   = {1'b0, acc_reg} + {1'b0, prod_reg};
                alu   = t49[47:0];
                flags_next[3] = flags_reg[3]
                    | (~(acc_reg[47] ^ prod_reg[47]) & (acc_reg[47] ^ t49[47]));
                flags_next[0] = t49[47];
                flags_next[1] = (t49[47:0] == 48'd0);
                flags_next[2] = t49[48];
            end
            default: upd32 = 1'b0;
        endcase
        if (upd32)
        begin
            alu           = {acc_reg[47:32], r};
            flags_next[0] = r[31];
            flags_next[1] = (r == 32'd0);
            flags_next[2] = c;
        end

        rd        = '0;
        inc       = '0;
        acc_next  = acc_reg;
        prod_next = prod_reg;
        rx_next   = rx_reg;
        ry_next   = ry_reg;
        rao_next  = rao_reg;
        wao_next  = wao_reg;
        loop_next = loop_reg;
        top_next  = top_reg;
        bank_we   = '0;

        if (q_data.x_mul)
        begin
            prod_next = mul[47:0];
        end
        if (q_data.x_rd)
        begin
            v = head[q_data.x_bank];
            rd[q_data.x_bank] = 1'b1;
            if (q_data.x_inc)
            begin
                inc[q_data.x_bank] = 1'b1;
            end
            if (q_data.x_ldp)
            begin
                prod_next = {{16{v[31]}}, v};
            end
            if (q_data.x_ldrx)
            begin
                rx_next = v;
            end
        end

        if (q_data.y_clr)
        begin
            acc_next = '0;
        end
        else if (q_data.y_alu)
        begin
            acc_next = alu;
        end
        if (q_data.y_rd)
        begin
            v = head[q_data.y_bank];
            rd[q_data.y_bank] = 1'b1;
            if (q_data.y_inc)
            begin
                inc[q_data.y_bank] = 1'b1;
            end
            if (q_data.y_ldac)
            begin
                acc_next = {{16{v[31]}}, v};
            end
            if (q_data.y_ldry)
            begin
                ry_next = v;
            end
        end

        v  = {{24{q_data.d1_field[7]}}, q_data.d1_field};
        sb = q_data.d1_field[1:0];
        if (q_data.d1_en && q_data.d1_reg)
        begin
            if (!q_data.d1_field[3])
            begin
                v = head[sb];
                rd[sb] = 1'b1;
                if (q_data.d1_field[2] && (q_data.d1_dest != {2'b00, sb}))
                begin
                    inc[sb] = 1'b1;
                end
            end
            else if (q_data.d1_field[3:0] == SRC_ALU_LO)
            begin
                v = alu[31:0];
            end
            else if (q_data.d1_field[3:0] == SRC_ALU_HI)
            begin
                v = alu[47:16];
            end
            else
            begin
                v = 32'hFFFF_FFFF;
            end
        end
        d1_val = v;

        if (q_data.d1_en)
        begin
            if (q_data.d1_dest[3:2] == 2'b00)
            begin
                if (!rd[q_data.d1_dest[1:0]])
                begin
                    bank_we[q_data.d1_dest[1:0]] = 1'b1;
                    inc[q_data.d1_dest[1:0]]     = 1'b1;
                end
            end
            else if (q_data.d1_dest[3:2] == 2'b11)
            begin
                inc[q_data.d1_dest[1:0]] = 1'b0;
            end
            else
            begin
                case (q_data.d1_dest)
                    DST_RX:  rx_next = v;
                    DST_P:   prod_next = {{16{v[31]}}, v};
                    DST_RAO: rao_next = v;
                    DST_WAO: wao_next = v;
                    DST_LOP:
                    begin
                        if (!q_data.looped || (loop_reg == LOP_FULL))
                        begin
                            loop_next = v[11:0];
                        end
                    end
                    DST_TOP: top_next = v[7:0];
                    default: ;
                endcase
            end
        end

        for (int i = 0; i < NUM_BANKS; i++)
        begin
            if (q_data.d1_en && (q_data.d1_dest[3:2] == 2'b11) && (q_data.d1_dest[1:0] == 2'(i)))
            begin
                addr_next[i] = v[CNT_W-1:0];
            end
            else
            begin
                addr_next[i] = addr_reg[i] + CNT_W'(inc[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            prod_reg      <= '0;
            rx_reg        <= '0;
            ry_reg        <= '0;
            flags_reg     <= '0;
            rao_reg       <= '0;
            wao_reg       <= '0;
            loop_reg      <= '0;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_BANKS; i++)
            begin
                addr_reg[i] <= '0;
            end
        end
        else
        begin
            if (fire)
            begin
                acc_reg   <= acc_next;
                prod_reg  <= prod_next;
                rx_reg    <= rx_next;
                ry_reg    <= ry_next;
                flags_reg <= flags_next;
                rao_reg   <= rao_next;
                wao_reg   <= wao_next;
                loop_reg  <= loop_next;
                top_reg   <= top_next;
                for (int i = 0; i < NUM_BANKS; i++)
                begin
                    addr_reg[i] <= addr_next[i];
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign accumulator   = acc_reg;
    assign product       = prod_reg;
    assign x_register    = rx_reg;
    assign y_register    = ry_reg;
    assign flag_sign     = flags_reg[0];
    assign flag_zero     = flags_reg[1];
    assign flag_carry    = flags_reg[2];
    assign flag_overflow = flags_reg[3] | (rao_reg[0] & 1'b0) | (wao_reg[0] & 1'b0);
    assign loop_count    = loop_reg;
    assign top_register  = top_reg;
    assign bank_counters = {addr_reg[3], addr_reg[2], addr_reg[1], addr_reg[0]};

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the DSP general instruction execute block.
// Depends on dgie_pkg and dsp_general_instruction_execute; runs directed then random instructions.
module tb;
    import dgie_pkg::*;

    localparam logic [3:0] DST_BANK0 = 4'd0;
    localparam logic [3:0] DST_BANK1 = 4'd1;
    localparam logic [3:0] DST_BANK2 = 4'd2;
    localparam logic [3:0] DST_BANK3 = 4'd3;
    localparam logic [3:0] DST_NONE8 = 4'd8;
    localparam logic [3:0] DST_NONE9 = 4'd9;
    localparam logic [3:0] DST_CNT0  = 4'd12;
    localparam logic [3:0] DST_CNT3  = 4'd15;
    localparam logic [7:0] SRC_BANK0 = 8'd0;
    localparam logic [7:0] SRC_BINC0 = 8'd4;
    localparam logic [7:0] SRC_ONES  = 8'd8;
    localparam logic [1:0] D1_OFF    = 2'd0;
    localparam logic [1:0] D1_IMM    = 2'd1;
    localparam logic [1:0] D1_REG    = 2'd3;
    localparam int WATCHDOG_LIMIT    = 5000;

    typedef struct packed {
        logic [47:0] acc;
        logic [47:0] prod;
        logic [31:0] rx;
        logic [31:0] ry;
        logic        s;
        logic        z;
        logic        c;
        logic        v;
        logic [11:0] lop;
        logic [7:0]  top;
        logic [23:0] cnts;
    } regs_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [3:0] operation = '0;
    logic [2:0] x_op = '0;
    logic [2:0] x_source = '0;
    logic [2:0] y_op = '0;
    logic [2:0] y_source = '0;
    logic [1:0] d1_op = '0;
    logic [3:0] d1_dest = '0;
    logic [7:0] d1_field = '0;
    logic looped = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [47:0] accumulator;
    logic [47:0] product;
    logic [31:0] x_register;
    logic [31:0] y_register;
    logic flag_sign;
    logic flag_zero;
    logic flag_carry;
    logic flag_overflow;
    logic [11:0] loop_count;
    logic [7:0] top_register;
    logic [23:0] bank_counters;

    logic [47:0] m_acc;
    logic [47:0] m_prod;
    logic [31:0] m_rx;
    logic [31:0] m_ry;
    logic m_s, m_z, m_c, m_v;
    logic [31:0] m_bank [4][64];
    logic [5:0] m_cnt [4];
    logic [31:0] m_rao;
    logic [31:0] m_wao;
    logic [11:0] m_lop;
    logic [7:0] m_top;

    regs_t expected_regs [$];
    int fail_count = 0;
    int idle_cycles = 0;
    bit no_stall = 1'b0;
    int stall_left = 0;

    dsp_general_instruction_execute u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .x_op(x_op), .x_source(x_source),
        .y_op(y_op), .y_source(y_source), .d1_op(d1_op), .d1_dest(d1_dest),
        .d1_field(d1_field), .looped(looped),
        .out_valid(out_valid), .out_ready(out_ready),
        .accumulator(accumulator), .product(product),
        .x_register(x_register), .y_register(y_register),
        .flag_sign(flag_sign), .flag_zero(flag_zero), .flag_carry(flag_carry),
        .flag_overflow(flag_overflow), .loop_count(loop_count),
        .top_register(top_register), .bank_counters(bank_counters)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [47:0] sext32(input logic [31:0] v);
        return {{16{v[31]}}, v};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_stall || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic reset_model();
        m_acc = '0; m_prod = '0; m_rx = '0; m_ry = '0;
        m_s = 0; m_z = 0; m_c = 0; m_v = 0;
        m_rao = '0; m_wao = '0; m_lop = '0; m_top = '0;
        for (int b = 0; b < 4; b++)
        begin
            m_cnt[b] = '0;
            for (int w = 0; w < 64; w++)
                m_bank[b][w] = '0;
        end
    endtask

    task automatic execute_instr(input logic [3:0] op, input logic [2:0] xo, input logic [2:0] xs,
                                 input logic [2:0] yo, input logic [2:0] ys, input logic [1:0] d1,
                                 input logic [3:0] dd, input logic [7:0] df, input logic lp);
        logic [47:0] alu;
        logic [31:0] a, p, r, v;
        logic [32:0] t33;
        logic [48:0] t49;
        logic signed [63:0] mul;
        logic [3:0] rd, inc;
        logic do32;
        logic [1:0] b;
        logic [3:0] s;
        regs_t e;
        alu = m_acc;
        a = m_acc[31:0];
        p = m_prod[31:0];
        rd = '0;
        inc = '0;
        do32 = 1'b1;
        r = '0;
        case (op)
            ALU_AND: begin r = a & p; m_c = 0; end
            ALU_OR:  begin r = a | p; m_c = 0; end
            ALU_XOR: begin r = a ^ p; m_c = 0; end
            ALU_ADD:
            begin
                t33 = {1'b0, a} + {1'b0, p};
                r = t33[31:0];
                m_v = m_v | (~(a[31] ^ p[31]) & (a[31] ^ r[31]));
                m_c = t33[32];
            end
            ALU_SUB:
            begin
                t33 = {1'b0, a} - {1'b0, p};
                r = t33[31:0];
                m_v = m_v | ((a[31] ^ p[31]) & (a[31] ^ r[31]));
                m_c = t33[32];
            end
            ALU_AD2:
            begin
                do32 = 1'b0;
                t49 = {1'b0, m_acc} + {1'b0, m_prod};
                m_v = m_v | (~(m_acc[47] ^ m_prod[47]) & (m_acc[47] ^ t49[47]));
                m_s = t49[47];
                m_z = (t49[47:0] == '0);
                m_c = t49[48];
                alu = t49[47:0];
            end
            ALU_SR:  begin r = {a[31], a[31:1]}; m_c = a[0]; end
            ALU_RR:  begin r = {a[0], a[31:1]}; m_c = a[0]; end
            ALU_SL:  begin r = {a[30:0], 1'b0}; m_c = a[31]; end
            ALU_RL:  begin r = {a[30:0], a[31]}; m_c = a[31]; end
            ALU_RL8: begin r = {a[23:0], a[31:24]}; m_c = a[24]; end
            default: do32 = 1'b0;
        endcase
        if (do32)
        begin
            alu = {m_acc[47:32], r};
            m_s = r[31];
            m_z = (r == '0);
        end

        if (xo[1:0] == 2'd2)
        begin
            mul = $signed(m_rx) * $signed(m_ry);
            m_prod = mul[47:0];
        end
        if (xo >= 3'd3)
        begin
            b = xs[1:0];
            v = m_bank[b][m_cnt[b]];
            rd[b] = 1'b1;
            if (xs[2])
                inc[b] = 1'b1;
            if (xo[1:0] == 2'd3)
                m_prod = sext32(v);
            if (xo[2])
                m_rx = v;
        end

        if (yo[1:0] == 2'd1)
            m_acc = '0;
        else if (yo[1:0] == 2'd2)
            m_acc = alu;
        if (yo >= 3'd3)
        begin
            b = ys[1:0];
            v = m_bank[b][m_cnt[b]];
            rd[b] = 1'b1;
            if (ys[2])
                inc[b] = 1'b1;
            if (yo[1:0] == 2'd3)
                m_acc = sext32(v);
            if (yo[2])
                m_ry = v;
        end

        if (d1[0])
        begin
            v = {{24{df[7]}}, df};
            if (d1[1])
            begin
                s = df[3:0];
                if (s < 4'd8)
                begin
                    b = s[1:0];
                    v = m_bank[b][m_cnt[b]];
                    rd[b] = 1'b1;
                    if (s >= 4'd4 && dd != {2'b00, b})
                        inc[b] = 1'b1;
                end
                else if (s == SRC_ALU_LO)
                    v = alu[31:0];
                else if (s == SRC_ALU_HI)
                    v = alu[47:16];
                else
                    v = '1;
            end
            if (dd < 4'd4)
            begin
                if (!rd[dd[1:0]])
                begin
                    m_bank[dd[1:0]][m_cnt[dd[1:0]]] = v;
                    inc[dd[1:0]] = 1'b1;
                end
            end
            else if (dd == DST_RX)
                m_rx = v;
            else if (dd == DST_P)
                m_prod = sext32(v);
            else if (dd == DST_RAO)
                m_rao = v;
            else if (dd == DST_WAO)
                m_wao = v;
            else if (dd == DST_LOP)
            begin
                if (!lp || m_lop == LOP_FULL)
                    m_lop = v[11:0];
            end
            else if (dd == DST_TOP)
                m_top = v[7:0];
            else if (dd >= DST_CNT0)
            begin
                m_cnt[dd[1:0]] = v[5:0];
                inc[dd[1:0]] = 1'b0;
            end
        end

        for (int i = 0; i < 4; i++)
            m_cnt[i] = m_cnt[i] + 6'(inc[i]);

        e.acc = m_acc; e.prod = m_prod; e.rx = m_rx; e.ry = m_ry;
        e.s = m_s; e.z = m_z; e.c = m_c; e.v = m_v;
        e.lop = m_lop; e.top = m_top;
        e.cnts = {m_cnt[3], m_cnt[2], m_cnt[1], m_cnt[0]};
        expected_regs.push_back(e);
    endtask

    task automatic send_instr(input logic [3:0] op, input logic [2:0] xo, input logic [2:0] xs,
                              input logic [2:0] yo, input logic [2:0] ys, input logic [1:0] d1,
                              input logic [3:0] dd, input logic [7:0] df, input logic lp);
        int gap;
        @(negedge clk);
        operation <= op; x_op <= xo; x_source <= xs; y_op <= yo; y_source <= ys;
        d1_op <= d1; d1_dest <= dd; d1_field <= df; looped <= lp;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        execute_instr(op, xo, xs, yo, ys, d1, dd, df, lp);
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_random(input bit shaped);
        logic [3:0] dd;
        dd = 4'($urandom_range(0, 15));
        if (shaped && $urandom_range(0, 3) == 0)
            dd = DST_CNT0 + 4'($urandom_range(0, 3));
        send_instr(4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                   3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                   3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), dd,
                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", field, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        regs_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_regs.size() == 0)
                report_mismatch("unexpected transfer", 0, 0);
            else
            begin
                e = expected_regs.pop_front();
                if (accumulator !== e.acc) report_mismatch("accumulator", accumulator, e.acc);
                if (product !== e.prod) report_mismatch("product", product, e.prod);
                if (x_register !== e.rx) report_mismatch("x_register", x_register, e.rx);
                if (y_register !== e.ry) report_mismatch("y_register", y_register, e.ry);
                if (flag_sign !== e.s) report_mismatch("flag_sign", flag_sign, e.s);
                if (flag_zero !== e.z) report_mismatch("flag_zero", flag_zero, e.z);
                if (flag_carry !== e.c) report_mismatch("flag_carry", flag_carry, e.c);
                if (flag_overflow !== e.v)
                    report_mismatch("flag_overflow", flag_overflow, e.v);
                if (loop_count !== e.lop) report_mismatch("loop_count", loop_count, e.lop);
                if (top_register !== e.top)
                    report_mismatch("top_register", top_register, e.top);
                if (bank_counters !== e.cnts)
                    report_mismatch("bank_counters", bank_counters, e.cnts);
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    task automatic test_alu_ops();
        logic [7:0] vals [4] = '{8'h7F, 8'h80, 8'hFF, 8'h00};
        for (int op = 0; op < 16; op++)
            send_instr(4'(op), 3'd0, 3'd0, 3'd2, 3'd0, D1_IMM, DST_P, vals[op % 4], 1'b0);
    endtask

    task automatic test_special_cases();
        send_instr(ALU_NOP, 3'd0, 3'd0, 3'd0, 3'd0, D1_IMM, DST_BANK1, 8'h80, 1'b0);
        // A bank read in the same instruction blocks the write and its increment.
        send_instr(ALU_NOP, 3'd7, 3'd1, 3'd0, 3'd0, D1_IMM, DST_BANK1, 8'h55, 1'b0);
        send_instr(ALU_NOP, 3'd7, 3'd6, 3'd7, 3'd6, D1_OFF, DST_BANK0, 8'h00, 1'b0);
        send_instr(ALU_NOP, 3'd2, 3'd0, 3'd0, 3'd0, D1_REG, DST_BANK2, SRC_BINC0 | 8'd2, 1'b0);
        send_instr(ALU_NOP, 3'd3, 3'd7, 3'd0, 3'd0, D1_IMM, DST_CNT3, 8'h3F, 1'b0);
        send_instr(ALU_NOP, 3'd3, 3'd7, 3'd0, 3'd0, D1_OFF, DST_CNT3, 8'h00, 1'b0);
        send_instr(ALU_NOP, 3'd0, 3'd0, 3'd0, 3'd0, D1_IMM, DST_NONE8, 8'hFF, 1'b0);
        send_instr(ALU_NOP, 3'd0, 3'd0, 3'd0, 3'd0, D1_IMM, DST_NONE9, 8'hFF, 1'b0);
        send_instr(ALU_NOP, 3'd0, 3'd0, 3'd0, 3'd0, D1_IMM, DST_LOP, 8'h05, 1'b1);
        send_instr(ALU_NOP, 3'd0, 3'd0, 3'd0, 3'd0, D1_REG, DST_LOP, SRC_ONES, 1'b0);
        send_instr(ALU_NOP, 3'd0, 3'd0, 3'd0, 3'd0, D1_IMM, DST_LOP, 8'h05, 1'b1);
        send_instr(ALU_ADD, 3'd0, 3'd0, 3'd0, 3'd0, D1_REG, DST_TOP, {4'd0, SRC_ALU_LO}, 1'b0);
        send_instr(ALU_AD2, 3'd0, 3'd0, 3'd0, 3'd0, D1_REG, DST_RX, {4'd0, SRC_ALU_HI}, 1'b0);
        send_instr(ALU_SUB, 3'd0, 3'd0, 3'd0, 3'd0, D1_REG, DST_RAO, 8'h0F, 1'b0);
        send_instr(ALU_NOP, 3'd0, 3'd0, 3'd0, 3'd0, D1_REG, DST_BANK3, SRC_BANK0, 1'b0);
    endtask

    task automatic test_random_instrs();
        no_stall = 1'b1;
        for (int i = 0; i < 100; i++)
            send_random(1'b1);
        no_stall = 1'b0;
        for (int i = 0; i < 450; i++)
            send_random(i % 2 == 0);
    endtask

    initial
    begin
        reset_model();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_alu_ops();
        test_special_cases();
        test_random_instrs();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (expected_regs.size() == 0);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+rtl
rtl/dgie_pkg.sv
rtl/dgie_front.sv
rtl/dgie_bank.sv
rtl/dgie_back.sv
rtl/dsp_general_instruction_execute.sv
tb/tb.sv
